[hw/rtl/lpfc_pkg.sv]
// Shared types, sizes and helper functions of the LRU page fault counter.
`timescale 1ns / 1ps
package lpfc_pkg;

  // Built store size and page key width.
  localparam int ENTRIES   = 16;
  localparam int PAGE_BITS = 16;

  // Widths fixed by the item fields and the capacity register.
  localparam int PAGE_IN_W = 16;
  localparam int TALLY_W   = 16;
  localparam int CAP_W     = 5;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Result of the associative search over all entries.
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    idx_t free_idx;
    idx_t victim_idx;
  } lookup_t;

  // Reduce an incoming page number to the stored key width.
  function automatic page_t page_key(logic [PAGE_IN_W-1:0] page);
    logic [PAGE_BITS+PAGE_IN_W-1:0] wide;
    wide = {{PAGE_BITS{1'b0}}, page};
    return wide[PAGE_BITS-1:0];
  endfunction

  // Clamp the programmed capacity into 1..ENTRIES.
  function automatic cnt_t eff_capacity(logic [CAP_W-1:0] cap);
    cnt_t res;
    if (cap == '0) begin
      res = cnt_t'(1);
    end else if (int'(cap) > ENTRIES) begin
      res = cnt_t'(ENTRIES);
    end else begin
      res = cnt_t'(cap);
    end
    return res;
  endfunction

endpackage

[hw/rtl/lpfc_lookup.sv]
// Parallel tag compare, free slot search and victim search over all entries.
`timescale 1ns / 1ps
module lpfc_lookup (
  input  lpfc_pkg::page_t [lpfc_pkg::ENTRIES-1:0] entry_page_i,
  input  logic            [lpfc_pkg::ENTRIES-1:0] entry_valid_i,
  input  lpfc_pkg::rank_t [lpfc_pkg::ENTRIES-1:0] entry_rank_i,
  input  lpfc_pkg::cnt_t                          occupied_i,
  input  lpfc_pkg::page_t                         key_i,
  output lpfc_pkg::lookup_t                       result_o
);

  lpfc_pkg::rank_t oldest_rank;

  // Valid ranks always form 0..occupied-1, so the oldest holds occupied-1.
  assign oldest_rank = lpfc_pkg::rank_t'(occupied_i - lpfc_pkg::cnt_t'(1));

  // Scanning downward lets the lowest matching index win each search.
  always_comb begin
    result_o = '0;
    for (int i = lpfc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid_i[i] && entry_page_i[i] == key_i) begin
        result_o.hit     = 1'b1;
        result_o.hit_idx = lpfc_pkg::idx_t'(i);
      end
      if (!entry_valid_i[i]) begin
        result_o.free_idx = lpfc_pkg::idx_t'(i);
      end
      if (entry_valid_i[i] && entry_rank_i[i] == oldest_rank) begin
        result_o.victim_idx = lpfc_pkg::idx_t'(i);
      end
    end
  end

endmodule

[hw/rtl/lpfc_store.sv]
// Entry registers with recency ranks, updated once per processed reference.
`timescale 1ns / 1ps
module lpfc_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  lpfc_pkg::page_t       key_i,
  input  logic                  last_i,
  input  lpfc_pkg::cnt_t        capacity_i,
  output logic                  hit_o
);

  lpfc_pkg::page_t [lpfc_pkg::ENTRIES-1:0] page_q, page_d;
  logic            [lpfc_pkg::ENTRIES-1:0] valid_q, valid_d;
  lpfc_pkg::rank_t [lpfc_pkg::ENTRIES-1:0] rank_q, rank_d;
  lpfc_pkg::cnt_t                          occupied_q, occupied_d;

  lpfc_pkg::lookup_t lookup;
  logic              fill;
  lpfc_pkg::idx_t    slot;
  lpfc_pkg::rank_t   hit_rank;

  lpfc_lookup u_lookup (
    .entry_page_i  (page_q),
    .entry_valid_i (valid_q),
    .entry_rank_i  (rank_q),
    .occupied_i    (occupied_q),
    .key_i         (key_i),
    .result_o      (lookup)
  );

  assign hit_o    = lookup.hit;
  assign fill     = !lookup.hit && (occupied_q < capacity_i);
  assign slot     = lookup.hit ? lookup.hit_idx :
                    (fill ? lookup.free_idx : lookup.victim_idx);
  assign hit_rank = rank_q[lookup.hit_idx];

  always_comb begin
    page_d     = page_q;
    valid_d    = valid_q;
    rank_d     = rank_q;
    occupied_d = occupied_q;
    if (advance_i) begin
      for (int i = 0; i < lpfc_pkg::ENTRIES; i++) begin
        if (lpfc_pkg::idx_t'(i) == slot) begin
          rank_d[i] = '0;
          if (!lookup.hit) begin
            page_d[i]  = key_i;
            valid_d[i] = 1'b1;
          end
        end else if (valid_q[i] && (!lookup.hit || rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + lpfc_pkg::rank_t'(1);
        end
      end
      if (fill) begin
        occupied_d = occupied_q + lpfc_pkg::cnt_t'(1);
      end
      if (last_i) begin
        valid_d    = '0;
        rank_d     = '0;
        occupied_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rank_q     <= '0;
      occupied_q <= '0;
    end else begin
      valid_q    <= valid_d;
      rank_q     <= rank_d;
      occupied_q <= occupied_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occupied_q))
    else $error("occupancy count does not match valid entries");

  a_hit_keeps_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && lookup.hit && !last_i) |=> $stable(occupied_q))
    else $error("hit changed occupancy");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && last_i) |=> (valid_q == '0 && occupied_q == '0))
    else $error("store not cleared after sequence end");

  a_victim_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && !lookup.hit && !fill) |-> valid_q[lookup.victim_idx])
    else $error("eviction picked an invalid entry");

endmodule

[hw/rtl/lru_page_fault_counter_top.sv]
// Top level of the LRU page fault counter: stream ports, item registers and fault tally.
`timescale 1ns / 1ps
// Each input item carries one page reference. The block models a fully
// associative page store of up to capacity entries under least-recently-used
// replacement. It returns one result item per reference, holding the fault
// flag and the running fault count of the current sequence, which saturates
// at its maximum. The item flagged with tlast ends a sequence: its result
// shows the final count and also carries tlast, after which all entries and
// the count are cleared. The block takes one item per clock cycle while the
// result side does not stall. Each item waits in the input register; its
// result is formed by the combinational parallel compare of all entries and
// the recency rank update, which sit between the input register and the
// result register. Capacity values of zero act as one and values above the
// built entry count act as that count. Capacity should be written only while
// no item is in flight.
module lru_page_fault_counter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Capacity register write port.
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // Reference items in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] page_number
  input  logic        s_axis_tlast,   // last_reference
  // Result items out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] fault, [16:1] fault_total, [23:17] zero
  output logic        m_axis_tlast    // sequence_end
);

  logic [lpfc_pkg::CAP_W-1:0] capacity_q;

  // Input register.
  logic                           in_valid_q, in_valid_d;
  logic [lpfc_pkg::PAGE_IN_W-1:0] in_page_q;
  logic                           in_last_q;

  // Result register.
  logic                         out_valid_q, out_valid_d;
  logic                         out_fault_q;
  logic [lpfc_pkg::TALLY_W-1:0] out_total_q;
  logic                         out_last_q;

  logic [lpfc_pkg::TALLY_W-1:0] tally_q, tally_d, tally_next;

  logic s_accept;
  logic advance;
  logic hit;

  // An item leaves the input register whenever the result register is free
  // or is being emptied in the same cycle, so the input side waits only
  // while a result item is held back by the result side.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  lpfc_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .key_i      (lpfc_pkg::page_key(in_page_q)),
    .last_i     (in_last_q),
    .capacity_i (lpfc_pkg::eff_capacity(capacity_q)),
    .hit_o      (hit)
  );

  // The fault tally saturates, and the last item of a sequence resets it
  // once its own result has been formed.
  always_comb begin
    tally_next = tally_q;
    if (!hit && tally_q != lpfc_pkg::TALLY_MAX) begin
      tally_next = tally_q + lpfc_pkg::TALLY_W'(1);
    end
    tally_d = tally_q;
    if (advance) begin
      tally_d = in_last_q ? '0 : tally_next;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= lpfc_pkg::CAP_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tally_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      tally_q     <= tally_d;
    end
  end

  // Payload registers load only on their handshake events.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_page_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance) begin
      out_fault_q <= !hit;
      out_total_q <= tally_next;
      out_last_q  <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_total_q, out_fault_q};
  assign m_axis_tlast  = out_last_q;

  a_tally_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (tally_q == '0))
    else $error("fault tally not cleared after sequence end");

  a_fault_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !hit && !in_last_q && tally_q != lpfc_pkg::TALLY_MAX)
      |=> (tally_q == $past(tally_q) + lpfc_pkg::TALLY_W'(1)))
    else $error("fault not counted");

  a_hit_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && hit) |=> (!out_fault_q && out_total_q == $past(tally_q)))
    else $error("hit changed the reported total");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

[bench/tb.sv]
// Self-checking testbench for the LRU page fault counter top level.
`timescale 1ns / 1ps

module tb;

  // The run ends with a failure if it is still going after this many cycles.
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RANDOM_PHASES = 15;
  localparam int unsigned PHASE_ITEMS = 50;

  // Expected content of one result item.
  typedef struct {
    logic        fault;
    logic [15:0] fault_total;
    logic        sequence_end;
  } fault_result_t;

  // Tracks the page store and checks result items in order.
  class lru_fault_scoreboard;
    lpfc_pkg::page_t slot_page [lpfc_pkg::ENTRIES];
    bit              slot_valid[lpfc_pkg::ENTRIES];
    lpfc_pkg::rank_t slot_rank [lpfc_pkg::ENTRIES];
    int unsigned     occupied;
    logic [15:0]     tally;
    logic [4:0]      capacity_reg;
    fault_result_t   awaited[$];
    int unsigned     errors;

    function new();
      clear_store();
      capacity_reg = lpfc_pkg::CAP_RESET;
      errors = 0;
    endfunction

    function void clear_store();
      for (int i = 0; i < lpfc_pkg::ENTRIES; i++) begin
        slot_page[i]  = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i]  = '0;
      end
      occupied = 0;
      tally = '0;
    endfunction

    function void write_capacity(logic [4:0] value);
      capacity_reg = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Ages every valid entry younger than the limit and makes slot the newest.
    function void age_and_promote(int slot, int limit);
      for (int i = 0; i < lpfc_pkg::ENTRIES; i++) begin
        if (slot_valid[i] && i != slot && int'(slot_rank[i]) < limit) begin
          slot_rank[i] = slot_rank[i] + 1'b1;
        end
      end
      slot_rank[slot] = '0;
    endfunction

    function void note_reference(logic [15:0] page_in, logic last);
      lpfc_pkg::page_t key;
      int              cap;
      int              slot;
      int              oldest;
      bit              hit;
      fault_result_t   res;
      key = page_in[lpfc_pkg::PAGE_BITS-1:0];
      cap = int'(capacity_reg);
      if (cap < 1) begin
        cap = 1;
      end
      if (cap > lpfc_pkg::ENTRIES) begin
        cap = lpfc_pkg::ENTRIES;
      end
      hit = 1'b0;
      slot = 0;
      for (int i = 0; i < lpfc_pkg::ENTRIES; i++) begin
        if (!hit && slot_valid[i] && slot_page[i] == key) begin
          hit = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        age_and_promote(slot, int'(slot_rank[slot]));
      end else begin
        if (tally != 16'hFFFF) begin
          tally = tally + 1'b1;
        end
        if (occupied < cap) begin
          // Fill the first free entry.
          for (int i = lpfc_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!slot_valid[i]) begin
              slot = i;
            end
          end
          slot_valid[slot] = 1'b1;
          occupied++;
        end else begin
          // Replace the oldest valid entry; ties go to the highest index.
          oldest = 0;
          for (int i = 0; i < lpfc_pkg::ENTRIES; i++) begin
            if (slot_valid[i] && int'(slot_rank[i]) >= oldest) begin
              oldest = int'(slot_rank[i]);
              slot = i;
            end
          end
        end
        slot_page[slot] = key;
        age_and_promote(slot, 255);
      end
      res.fault = !hit;
      res.fault_total = tally;
      res.sequence_end = last;
      awaited.insert(awaited.size(), res);
      if (last) begin
        clear_store();
      end
    endfunction

    function void check_result(logic [23:0] data, logic last);
      fault_result_t exp;
      if (awaited.size() == 0) begin
        $error("result item with none awaited: tdata=%h tlast=%b", data, last);
        errors++;
        return;
      end
      exp = awaited[0];
      awaited.delete(0);
      if (data[0] !== exp.fault) begin
        $error("fault: expected %0d, actual %0d", exp.fault, data[0]);
        errors++;
      end
      if (data[16:1] !== exp.fault_total) begin
        $error("fault_total: expected %0d, actual %0d", exp.fault_total, data[16:1]);
        errors++;
      end
      if (data[23:17] !== 7'd0) begin
        $error("tdata padding: expected %0d, actual %0d", 7'd0, data[23:17]);
        errors++;
      end
      if (last !== exp.sequence_end) begin
        $error("sequence_end: expected %0d, actual %0d", exp.sequence_end, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned cycle_count = 0;

  lru_fault_scoreboard sb = new();

  lru_page_fault_counter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** lru_page_fault_counter_top: FAILED **");
      $finish;
    end
  end

  // Every accepted result item is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  // The result side stalls a random number of cycles before each item.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = $urandom_range(10, 0);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
    end
  end

  // Offers one page reference and returns at the edge where it is taken.
  task automatic send_ref(logic [15:0] page, logic last);
    int unsigned gap;
    gap = $urandom_range(10, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= page;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_reference(page, last);
  endtask

  // Waits until every result has come back and the pipeline has emptied.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_capacity(value);
  endtask

  // Random references, mostly drawn from a small page pool so that hits and
  // evictions both happen often; the rest are arbitrary pages.
  task automatic run_random_phase(int unsigned count);
    logic [15:0] pool[24];
    int unsigned pool_size;
    logic [15:0] page;
    logic        last;
    pool_size = $urandom_range(24, 2);
    for (int i = 0; i < 24; i++) begin
      pool[i] = 16'($urandom);
    end
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(9, 0) < 8) begin
        page = pool[$urandom_range(pool_size - 1, 0)];
      end else begin
        page = 16'($urandom);
      end
      last = ($urandom_range(24, 0) == 0);
      send_ref(page, last);
    end
  endtask

  function automatic logic [4:0] pick_capacity();
    logic [4:0] cap;
    case ($urandom_range(6, 0))
      0: cap = 5'd0;
      1: cap = 5'd31;
      2: cap = 5'd16;
      3: cap = 5'($urandom_range(31, 17));
      4: cap = 5'($urandom_range(31, 0));
      default: cap = 5'($urandom_range(8, 1));
    endcase
    return cap;
  endfunction

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Capacity as it comes out of reset, with the extreme page numbers.
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b1);

    // A capacity of zero behaves as a single entry.
    write_capacity(5'd0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0008, 1'b0);
    send_ref(16'h0007, 1'b1);

    // Two entries: the least recently used one is evicted on a miss.
    write_capacity(5'd2);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0001, 1'b1);

    // Capacity lowered in the middle of a sequence keeps the filled entries,
    // then a value above the built size lets misses fill free entries again.
    write_capacity(5'd4);
    send_ref(16'h0010, 1'b0);
    send_ref(16'h0011, 1'b0);
    send_ref(16'h0012, 1'b0);
    send_ref(16'h0013, 1'b0);
    write_capacity(5'd2);
    send_ref(16'h0011, 1'b0);
    send_ref(16'h0020, 1'b0);
    send_ref(16'h0012, 1'b0);
    write_capacity(5'd31);
    send_ref(16'h0021, 1'b0);
    send_ref(16'h0022, 1'b1);

    // Random phases, each under its own capacity. Phases often end without
    // a last reference, so capacity changes mid-sequence.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      write_capacity(pick_capacity());
      run_random_phase(PHASE_ITEMS);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** lru_page_fault_counter_top: PASSED **");
    end else begin
      $display("** lru_page_fault_counter_top: FAILED **");
    end
    $finish;
  end

endmodule
